/* rtl/core/lsps_pkg.sv */
// ----------------------------------------------------------------------------
// lsps_pkg: shared types and constants of the LED strip pixel serializer
// Command codes, line byte patterns and the 5-bit to 8-bit gamma curve.
// ----------------------------------------------------------------------------
package lsps_pkg;

  typedef logic [2:0]  cmd_t;
  typedef logic [4:0]  chan5_t;
  typedef logic [7:0]  chan8_t;
  typedef logic [14:0] pixel_t;

  // command codes
  localparam cmd_t CMD_SET      = 3'd0;
  localparam cmd_t CMD_SET_DIM  = 3'd1;
  localparam cmd_t CMD_READ     = 3'd2;
  localparam cmd_t CMD_SEND     = 3'd3;
  localparam cmd_t CMD_SEND_RAW = 3'd4;

  // line patterns for one data bit
  localparam chan8_t BYTE_ONE  = 8'h7E;
  localparam chan8_t BYTE_ZERO = 8'h70;

  localparam int unsigned BITS_PER_PIXEL = 24;

  // gamma curve applied to stored channels on the way out
  function automatic chan8_t gamma5(input chan5_t v);
    chan8_t g;
    unique case (v)
      5'd0:  g = 8'd0;
      5'd1:  g = 8'd1;
      5'd2:  g = 8'd1;
      5'd3:  g = 8'd2;
      5'd4:  g = 8'd3;
      5'd5:  g = 8'd4;
      5'd6:  g = 8'd6;
      5'd7:  g = 8'd7;
      5'd8:  g = 8'd9;
      5'd9:  g = 8'd10;
      5'd10: g = 8'd13;
      5'd11: g = 8'd15;
      5'd12: g = 8'd18;
      5'd13: g = 8'd21;
      5'd14: g = 8'd24;
      5'd15: g = 8'd28;
      5'd16: g = 8'd33;
      5'd17: g = 8'd38;
      5'd18: g = 8'd44;
      5'd19: g = 8'd50;
      5'd20: g = 8'd58;
      5'd21: g = 8'd67;
      5'd22: g = 8'd77;
      5'd23: g = 8'd88;
      5'd24: g = 8'd101;
      5'd25: g = 8'd115;
      5'd26: g = 8'd132;
      5'd27: g = 8'd150;
      5'd28: g = 8'd172;
      5'd29: g = 8'd196;
      5'd30: g = 8'd224;
      5'd31: g = 8'd255;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

/* rtl/core/led_strip_pixel_serializer_unit.sv */
// ----------------------------------------------------------------------------
// led_strip_pixel_serializer_unit: pixel store and one-wire SPI bit encoder
// Keeps 5-bit-per-channel colours in a RAM and sends pixels as 24 line bytes.
// ----------------------------------------------------------------------------
//  channel | handshake          | carries
//  in_     | in_valid/in_ready  | command, index, colour, brightness, frame end
//  out_    | out_valid/out_ready| line byte or read-back colour with flags
//  cfg_    | cfg_we             | num_leds (11 bits)
//
// Set and set dimmed pass IDLE and EXEC; read back adds MEM (skipped for an index
// out of range) and RESP; unknown commands and an out-of-range send end at EXEC.
// A send emits one line byte per cycle, while the output is not stalled, from a
// 24-bit shift register; a stored pixel first passes the MEM state for its RAM read.
// After reset a clearing pass writes zero to all MAX_LEDS entries, one a
// cycle; in_ready stays low until the pass is done.
// out_ready low holds the current result and pauses the shift register.
module led_strip_pixel_serializer_unit #(
  parameter int MAX_LEDS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lsps_pkg::cmd_t        in_cmd,
  input  logic [9:0]            in_led_index,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_brightness,
  input  logic                  in_frame_end,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [7:0]            out_spi_byte,
  output logic [7:0]            out_red_out,
  output logic [7:0]            out_green_out,
  output logic [7:0]            out_blue_out,
  output logic                  out_valid_res,
  output logic                  out_last,
  output logic                  out_frame_done,
  // configuration
  input  logic                  cfg_we,
  input  logic [10:0]           cfg_wdata
);
  import lsps_pkg::*;

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MEM   = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;

  localparam logic [4:0] LAST_BIT = 5'(BITS_PER_PIXEL - 1);

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [10:0]   num_leds_r, num_leds_nxt;
  logic [4:0]    bit_cnt_r, bit_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // item and result payload
  cmd_t          cmd_r;
  logic [9:0]    idx_r;
  chan8_t        red_r, green_r, blue_r, bright_r;
  logic          fend_r;
  pixel_t        px_r, px_nxt;
  logic          px_ok_r, px_ok_nxt;
  logic [23:0]   shift_r, shift_nxt;
  logic          out_kind_r, out_kind_nxt;
  chan8_t        out_byte_r, out_byte_nxt;
  chan8_t        out_red_r, out_red_nxt;
  chan8_t        out_green_r, out_green_nxt;
  chan8_t        out_blue_r, out_blue_nxt;
  logic          out_vres_r, out_vres_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_fdone_r, out_fdone_nxt;

  // memory port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, item_addr;
  pixel_t        ram_wdata, ram_rdata;

  logic          in_acc, out_free, idx_ok;
  logic [12:0]   idx_wide;
  logic [15:0]   prod_red, prod_green, prod_blue;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // index check against the configured count and the store depth
  assign idx_wide  = {3'b000, idx_r};
  assign item_addr = idx_wide[AW-1:0];
  assign idx_ok    = ({1'b0, idx_r} < num_leds_r) && (idx_wide < 13'(MAX_LEDS));

  // dimming products; the stored channel is the top five product bits
  assign prod_red   = red_r * bright_r;
  assign prod_green = green_r * bright_r;
  assign prod_blue  = blue_r * bright_r;

  lsps_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_LEDS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (item_addr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    num_leds_nxt  = cfg_we ? cfg_wdata : num_leds_r;
    bit_cnt_nxt   = bit_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    px_nxt        = px_r;
    px_ok_nxt     = px_ok_r;
    shift_nxt     = shift_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    out_vres_nxt  = out_vres_r;
    out_last_nxt  = out_last_r;
    out_fdone_nxt = out_fdone_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = item_addr;
    ram_wdata     = '0;

    unique case (state_r)
      // zero one store entry per cycle
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        if (clr_cnt_r == AW'(MAX_LEDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      // decode the held item
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (cmd_r)
          CMD_SET: begin
            ram_we    = idx_ok;
            ram_wdata = {red_r[7:3], green_r[7:3], blue_r[7:3]};
          end
          CMD_SET_DIM: begin
            ram_we    = idx_ok;
            ram_wdata = {prod_red[15:11], prod_green[15:11], prod_blue[15:11]};
          end
          CMD_READ: begin
            if (idx_ok) begin
              ram_re    = 1'b1;
              state_nxt = S_MEM;
            end else begin
              px_ok_nxt = 1'b0;
              px_nxt    = '0;
              state_nxt = S_RESP;
            end
          end
          CMD_SEND: begin
            if (idx_ok) begin
              ram_re    = 1'b1;
              state_nxt = S_MEM;
            end
          end
          CMD_SEND_RAW: begin
            shift_nxt   = {green_r, red_r, blue_r};
            bit_cnt_nxt = LAST_BIT;
            state_nxt   = S_SHIFT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      // stored pixel arrives
      S_MEM: begin
        if (cmd_r == CMD_READ) begin
          px_nxt    = ram_rdata;
          px_ok_nxt = 1'b1;
          state_nxt = S_RESP;
        end else begin
          shift_nxt   = {gamma5(ram_rdata[9:5]), gamma5(ram_rdata[14:10]),
                         gamma5(ram_rdata[4:0])};
          bit_cnt_nxt = LAST_BIT;
          state_nxt   = S_SHIFT;
        end
      end
      // hand out the read-back item
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b1;
          out_byte_nxt  = '0;
          out_red_nxt   = {px_r[14:10], 3'b000};
          out_green_nxt = {px_r[9:5], 3'b000};
          out_blue_nxt  = {px_r[4:0], 3'b000};
          out_vres_nxt  = px_ok_r;
          out_last_nxt  = 1'b0;
          out_fdone_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      // advance one data bit per accepted line byte
      S_SHIFT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = 1'b0;
          out_byte_nxt  = shift_r[23] ? BYTE_ONE : BYTE_ZERO;
          out_red_nxt   = '0;
          out_green_nxt = '0;
          out_blue_nxt  = '0;
          out_vres_nxt  = 1'b1;
          out_last_nxt  = (bit_cnt_r == '0);
          out_fdone_nxt = (bit_cnt_r == '0) && fend_r;
          shift_nxt     = {shift_r[22:0], 1'b0};
          if (bit_cnt_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            bit_cnt_nxt = bit_cnt_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      num_leds_r  <= 11'd1024;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      num_leds_r  <= num_leds_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_cmd;
      idx_r    <= in_led_index;
      red_r    <= in_red;
      green_r  <= in_green;
      blue_r   <= in_blue;
      bright_r <= in_brightness;
      fend_r   <= in_frame_end;
    end
    px_r        <= px_nxt;
    px_ok_r     <= px_ok_nxt;
    shift_r     <= shift_nxt;
    out_kind_r  <= out_kind_nxt;
    out_byte_r  <= out_byte_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_vres_r  <= out_vres_nxt;
    out_last_r  <= out_last_nxt;
    out_fdone_r <= out_fdone_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_spi_byte   = out_byte_r;
  assign out_red_out    = out_red_r;
  assign out_green_out  = out_green_r;
  assign out_blue_out   = out_blue_r;
  assign out_valid_res  = out_vres_r;
  assign out_last       = out_last_r;
  assign out_frame_done = out_fdone_r;

  // an accepted item keeps in_ready low in the cycle after it
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken twice in a row");

  // frame end only rides on the final byte of a pixel
  a_fdone_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last && !out_kind)
    else $error("frame_done without last byte");

  // store writes only while clearing or executing a set
  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR) || (state_r == S_EXEC))
    else $error("store written outside clear or set");

  // bit counter stays within one pixel
  a_bit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> bit_cnt_r <= LAST_BIT)
    else $error("bit counter out of range");

endmodule

/* rtl/core/lsps_ram.sv */
// ----------------------------------------------------------------------------
// lsps_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lsps_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
